>>> hdl/rarm_pkg.sv
// Shared types and constants for the rational add / multiply / reduce core.
// No dependencies; every other file in hdl/ refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package rarm_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 31;
  localparam int MAG_W         = 32;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_MUL = 2'd1;
  localparam logic [1:0] KIND_RED = 2'd2;
  // only the high bit of kind selects reduce, so kind 3 also reduces
  localparam int KIND_REDUCE_BIT = 1;

  typedef struct packed {
    logic [1:0]                      kind;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } op_item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    zero_den_error;
  } res_item_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_PREP,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_QN_START,
    ST_QN_WAIT,
    ST_QD_START,
    ST_QD_WAIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> hdl/rarm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rarm_pkg (widths and request / response structs).
`timescale 1ns / 1ps
`default_nettype none

module rarm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rarm_pkg::div_req_t req,
  output rarm_pkg::div_rsp_t      rsp
);

  localparam int W    = rarm_pkg::MAG_W;
  localparam int CntW = $clog2(W);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [W-1:0]    divisor;
  logic [W-1:0]    quo;
  logic [W-1:0]    rem;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       take;

  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = shifted - {1'b0, divisor};
    take    = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        quo <= {quo[W-2:0], take};
        rem <= take ? diff[W-1:0] : shifted[W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

>>> hdl/rational_add_multiply_reduce_core.sv
// Rational add / multiply / reduce core: sequencer, shared multiplier, Euclid control.
// Depends on rarm_pkg and rarm_div.
// Sequence: a zero denominator goes from MUL0 straight to FINISH, a zero numerator from PREP;
//   else k Euclid remainder steps (data dependent, <= ~46), then the divisions for num and den.
// Throughput: one item at a time, the next taken the cycle after the result loads.
// Reset (rst, synchronous): sequencer to idle, result channel empty, divider idle.
`timescale 1ns / 1ps
`default_nettype none

module rational_add_multiply_reduce_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  output logic                    op_stall,
  input  wire rarm_pkg::op_item_t op,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output rarm_pkg::res_item_t     res
);

  localparam int OW = rarm_pkg::OPERAND_WIDTH;
  localparam int NW = rarm_pkg::NUM_W;
  localparam int MW = rarm_pkg::MAG_W;
  localparam int DW = rarm_pkg::DEN_W;

  rarm_pkg::state_t state, state_next;

  // captured operands
  rarm_pkg::op_item_t op_r;
  logic               err_r;

  // datapath
  logic signed [MW-1:0] prod;      // registered multiplier output
  logic signed [NW-1:0] acc;       // raw numerator for add / multiply
  logic [MW-1:0]        mn, md;    // magnitudes of raw numerator / denominator
  logic [MW-1:0]        x, y;      // Euclid pair; x ends as the gcd
  logic [MW-1:0]        qn, qd;
  logic                 neg;

  rarm_pkg::div_req_t div_req;
  rarm_pkg::div_rsp_t div_rsp;

  logic accept_in;
  logic only_a;
  logic is_add;
  logic out_free;

  assign accept_in = op_valid & ~op_stall;
  assign op_stall  = (state != rarm_pkg::ST_IDLE);
  assign only_a    = op_r.kind[rarm_pkg::KIND_REDUCE_BIT];
  assign is_add    = (op_r.kind == rarm_pkg::KIND_ADD);
  assign out_free  = ~res_valid | ~res_stall;

  // ---------------------------------------------------------------
  // Shared multiplier: one 16x16 signed product per cycle.
  //   MUL0: a_num * (add ? b_den : b_num)
  //   MUL1: a_den * b_num
  //   MUL2: a_den * b_den
  // ---------------------------------------------------------------
  logic signed [OW-1:0] ma, mb;
  logic signed [MW-1:0] mprod;

  always_comb begin
    case (state)
      rarm_pkg::ST_MUL0: begin
        ma = op_r.a_num;
        mb = is_add ? op_r.b_den : op_r.b_num;
      end
      rarm_pkg::ST_MUL1: begin
        ma = op_r.a_den;
        mb = op_r.b_num;
      end
      default: begin
        ma = op_r.a_den;
        mb = op_r.b_den;
      end
    endcase
    mprod = MW'(ma) * MW'(mb);
  end

  // raw fraction selected in PREP
  logic signed [NW-1:0] num_raw;
  logic signed [MW-1:0] den_raw;
  logic signed [NW-1:0] num_neg;
  logic signed [MW-1:0] den_neg;

  always_comb begin
    num_raw = only_a ? NW'(op_r.a_num) : acc;
    den_raw = only_a ? MW'(op_r.a_den) : prod;
    num_neg = -num_raw;
    den_neg = -den_raw;
  end

  // ---------------------------------------------------------------
  // Sequencer: next state and divider requests
  // ---------------------------------------------------------------
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = x;
    div_req.divisor  = y;
    case (state)
      rarm_pkg::ST_IDLE:   if (accept_in) state_next = rarm_pkg::ST_MUL0;
      rarm_pkg::ST_MUL0:   state_next = err_r ? rarm_pkg::ST_FINISH : rarm_pkg::ST_MUL1;
      rarm_pkg::ST_MUL1:   state_next = rarm_pkg::ST_MUL2;
      rarm_pkg::ST_MUL2:   state_next = rarm_pkg::ST_PREP;
      rarm_pkg::ST_PREP: begin
        state_next = (num_raw == '0) ? rarm_pkg::ST_FINISH : rarm_pkg::ST_GCD_START;
      end
      rarm_pkg::ST_GCD_START: begin
        if (y == '0) begin
          state_next = rarm_pkg::ST_QN_START;
        end else begin
          div_req.start = 1'b1;
          state_next    = rarm_pkg::ST_GCD_WAIT;
        end
      end
      rarm_pkg::ST_GCD_WAIT: if (div_rsp.done) state_next = rarm_pkg::ST_GCD_START;
      rarm_pkg::ST_QN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = mn;
        div_req.divisor  = x;
        state_next       = rarm_pkg::ST_QN_WAIT;
      end
      rarm_pkg::ST_QN_WAIT: if (div_rsp.done) state_next = rarm_pkg::ST_QD_START;
      rarm_pkg::ST_QD_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = md;
        div_req.divisor  = x;
        state_next       = rarm_pkg::ST_QD_WAIT;
      end
      rarm_pkg::ST_QD_WAIT: if (div_rsp.done) state_next = rarm_pkg::ST_FINISH;
      rarm_pkg::ST_FINISH: if (out_free) state_next = rarm_pkg::ST_IDLE;
      default: state_next = rarm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rarm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      rarm_pkg::ST_IDLE: begin
        if (accept_in) begin
          op_r  <= op;
          err_r <= (op.a_den == '0) ||
                   (!op.kind[rarm_pkg::KIND_REDUCE_BIT] && (op.b_den == '0));
        end
      end
      rarm_pkg::ST_MUL0: begin
        prod <= mprod;
      end
      rarm_pkg::ST_MUL1: begin
        acc  <= NW'(prod);
        prod <= mprod;
      end
      rarm_pkg::ST_MUL2: begin
        if (is_add) acc <= acc + NW'(prod);
        prod <= mprod;
      end
      rarm_pkg::ST_PREP: begin
        // sign goes to the numerator, denominator made positive
        neg <= (num_raw == '0) ? 1'b0 : (num_raw[NW-1] ^ den_raw[MW-1]);
        mn  <= num_raw[NW-1] ? num_neg[MW-1:0] : num_raw[MW-1:0];
        md  <= den_raw[MW-1] ? den_neg : den_raw;
        x   <= num_raw[NW-1] ? num_neg[MW-1:0] : num_raw[MW-1:0];
        y   <= den_raw[MW-1] ? den_neg : den_raw;
        if (num_raw == '0) begin
          qn  <= '0;
          qd  <= MW'(1);
        end
      end
      rarm_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          x <= y;
          y <= div_rsp.rem;
        end
      end
      rarm_pkg::ST_QN_WAIT: if (div_rsp.done) qn <= div_rsp.quo;
      rarm_pkg::ST_QD_WAIT: if (div_rsp.done) qd <= div_rsp.quo;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Result register: loaded from FINISH once the slot is free
  // ---------------------------------------------------------------
  logic signed [NW-1:0] qn_s;
  assign qn_s = $signed({1'b0, qn});

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (state == rarm_pkg::ST_FINISH && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (state == rarm_pkg::ST_FINISH && out_free) begin
      if (err_r) begin
        res.res_num        <= '0;
        res.res_den        <= '0;
        res.zero_den_error <= 1'b1;
      end else begin
        res.res_num        <= neg ? -qn_s : qn_s;
        res.res_den        <= qd[DW-1:0];
        res.zero_den_error <= 1'b0;
      end
    end
  end

  rarm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_den_error |-> res.res_num == '0 && res.res_den == '0)
    else $error("error item with nonzero fields");

  a_den_positive: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.zero_den_error |-> res.res_den != '0)
    else $error("zero denominator on a good item");

  a_zero_num_den_one: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.zero_den_error && res.res_num == '0 |-> res.res_den == DW'(1))
    else $error("zero numerator without unit denominator");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == rarm_pkg::ST_FINISH)
    else $error("result loaded outside finish");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

endmodule

`default_nettype wire

>>> verif/tb_rational_add_multiply_reduce_core.sv
// Self-checking testbench for rational_add_multiply_reduce_core: directed corners, then
// random fraction items under bursty input and stalling output. Depends on rarm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rational_add_multiply_reduce_core;

  typedef rarm_pkg::op_item_t  op_item_t;
  typedef rarm_pkg::res_item_t res_item_t;

  localparam int         OPERAND_WIDTH   = rarm_pkg::OPERAND_WIDTH;
  localparam int         NUM_W           = rarm_pkg::NUM_W;
  localparam int         DEN_W           = rarm_pkg::DEN_W;
  localparam int         KIND_REDUCE_BIT = rarm_pkg::KIND_REDUCE_BIT;
  localparam logic [1:0] KIND_ADD        = rarm_pkg::KIND_ADD;
  localparam logic [1:0] KIND_MUL        = rarm_pkg::KIND_MUL;
  localparam logic [1:0] KIND_RED        = rarm_pkg::KIND_RED;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

  // kind 3 is not a named operation, but the core decodes it as a reduce
  localparam logic [1:0]  KIND_RED_ALT  = 2'd3;
  localparam int          RANDOM_ITEMS  = 1700;
  localparam int          HOLD_AT_ITEM  = 300;     // random item count that arms the hold-off
  localparam int          HOLD_CYCLES   = 4000;    // longer than the worst item latency
  localparam int          DRAIN_CYCLES  = 200;
  // worst item: Euclid/divide plus output stall and input gap;
  // ~1.7k items, then several times over
  localparam int unsigned LIMIT_CYCLES  = 12_000_000;

  // Expected-result store: one reduced fraction per accepted item, in order.
  class fraction_scoreboard;
    res_item_t   awaited_fractions[$];
    int unsigned fault_count;

    // Reduced form of the fraction that one item describes.
    static function res_item_t reduced_fraction(op_item_t it);
      res_item_t         r;
      logic              only_a;
      logic              neg;
      longint            an, ad, bn, bd, num, den, signed_q;
      longint unsigned   mn, md, x, y, rem, qn, qd;
      r = '0;
      only_a = it.kind[KIND_REDUCE_BIT];
      an = $signed(it.a_num);
      ad = $signed(it.a_den);
      bn = $signed(it.b_num);
      bd = $signed(it.b_den);
      // a used zero denominator: flag only, all other fields zero
      if (ad == 0 || (!only_a && bd == 0)) begin
        r.zero_den_error = 1'b1;
        return r;
      end
      if (only_a) begin
        num = an;
        den = ad;
      end else if (it.kind == KIND_ADD) begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end else begin
        num = an * bn;
        den = ad * bd;
      end
      if (num == 0) begin
        r.res_den = DEN_W'(1);
        return r;
      end
      neg = (num < 0) != (den < 0);
      mn = (num < 0) ? longint'(-num) : longint'(num);
      md = (den < 0) ? longint'(-den) : longint'(den);
      x = mn;
      y = md;
      while (y != 0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      qn = mn / x;
      qd = md / x;
      signed_q = neg ? -longint'(qn) : longint'(qn);
      r.res_num = signed_q[NUM_W-1:0];
      r.res_den = qd[DEN_W-1:0];
      return r;
    endfunction

    function void note_operands(op_item_t it);
      awaited_fractions.push_back(reduced_fraction(it));
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (awaited_fractions.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result: expected none, got num %0d den %0d err %0b",
                 $time, got.res_num, got.res_den, got.zero_den_error);
        return;
      end
      want = awaited_fractions.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.zero_den_error !== want.zero_den_error) begin
        fault_count++;
        $display("%0t: mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                 $time, want.res_num, want.res_den, want.zero_den_error,
                 got.res_num, got.res_den, got.zero_den_error);
      end
    endfunction

    function int outstanding();
      return awaited_fractions.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        op_valid;
  logic        op_stall;
  op_item_t    op;
  logic        res_valid;
  logic        res_stall;
  res_item_t   res;

  logic        long_hold_armed;   // set once by the sender, watched by the result sink
  int unsigned cycle_count = 0;

  fraction_scoreboard sb = new;

  rational_add_multiply_reduce_core dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung core or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("rational_add_multiply_reduce_core verification failed");
      $finish;
    end
  end

  // Result monitor. Stall and valid are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result(res);
  end

  // Result sink: stall patterns that change over randomly sized spans, plus one
  // long hold-off so results back up and the core has to stall its input.
  initial begin : result_sink
    int mode;
    int span;
    int k;
    bit long_hold_done;
    long_hold_done = 1'b0;
    res_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (long_hold_armed && !long_hold_done) begin
          long_hold_done = 1'b1;
          res_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       res_stall <= 1'b0;                          // no backpressure
          1:       res_stall <= ($urandom_range(0, 3) == 0);
          2:       res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= ((k % 8) >= 5);                // periodic
        endcase
      end
    end
  end

  // Offer one item and hold it until the core takes it. Called at a rising edge;
  // returns at the edge of acceptance with op_valid still high.
  task automatic send_item(input op_item_t it);
    op       <= it;
    op_valid <= 1'b1;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    sb.note_operands(it);
  endtask

  function automatic op_item_t make_op(logic [1:0] kind, operand_t an, operand_t ad,
                                       operand_t bn, operand_t bd);
    op_item_t it;
    it.kind  = kind;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // Mostly small magnitudes to keep Euclid short; some 12-bit, some full range, some corners.
  function automatic operand_t pick_operand();
    int          sel;
    int          s;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    v   = $urandom;
    if (sel < 55) begin
      s = int'($urandom_range(0, 80)) - 40;
      return s[OPERAND_WIDTH-1:0];
    end else if (sel < 78) begin
      return {{4{v[11]}}, v[11:0]};
    end else if (sel < 92) begin
      return v[OPERAND_WIDTH-1:0];
    end
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh8001;
      3:       return -16'sd1;
      4:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic op_item_t random_op();
    logic [1:0] kind;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: kind = KIND_ADD;
      4, 5, 6, 7: kind = KIND_MUL;
      8:          kind = KIND_RED;
      default:    kind = KIND_RED_ALT;
    endcase
    return make_op(kind, pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endfunction

  initial begin : stimulus
    op_item_t directed[$];
    int       sent;
    int       burst;
    int       gap;
    int       i;

    rst             <= 1'b1;
    op_valid        <= 1'b0;
    op              <= '0;
    long_hold_armed <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    directed.push_back(make_op(KIND_ADD,     16'sd1,      16'sd2,      16'sd1,      16'sd3));
    directed.push_back(make_op(KIND_MUL,     16'sd2,      16'sd3,      16'sd3,      16'sd4));
    directed.push_back(make_op(KIND_RED,     16'sd6,     -16'sd8,      16'sd5,      16'sd7));
    // reduce ignores the second fraction, even a zero denominator there
    directed.push_back(make_op(KIND_RED_ALT, 16'sd10,     16'sd4,      16'sd9,      16'sd0));
    directed.push_back(make_op(KIND_RED,    -16'sd9,      16'sd12,    -16'sd1,      16'sd0));
    // zero denominators that the operation uses
    directed.push_back(make_op(KIND_ADD,     16'sd5,      16'sd0,      16'sd1,      16'sd2));
    directed.push_back(make_op(KIND_MUL,     16'sd5,      16'sd3,      16'sd1,      16'sd0));
    directed.push_back(make_op(KIND_ADD,     16'sd5,      16'sd3,      16'sd1,      16'sd0));
    directed.push_back(make_op(KIND_RED,     16'sd5,      16'sd0,      16'sd1,      16'sd1));
    // zero numerators come out as 0/1
    directed.push_back(make_op(KIND_ADD,     16'sd1,      16'sd2,     -16'sd1,      16'sd2));
    directed.push_back(make_op(KIND_MUL,     16'sd0,      16'sd5,      16'sd7,     -16'sd3));
    directed.push_back(make_op(KIND_RED,     16'sd0,     -16'sd7,      16'sd0,      16'sd0));
    // extremes of the operand range
    directed.push_back(make_op(KIND_ADD,     16'sh8000,   16'sh8000,   16'sh8000,   16'sh8000));
    directed.push_back(make_op(KIND_ADD,     16'sh8000,   16'sh7fff,   16'sh8000,   16'sh7fff));
    directed.push_back(make_op(KIND_ADD,     16'sh7fff,   16'sh8000,   16'sh7fff,   16'sh8001));
    directed.push_back(make_op(KIND_MUL,     16'sh8000,   16'sh7fff,   16'sh8000,   16'sh7ffd));
    directed.push_back(make_op(KIND_MUL,     16'sh7fff,   16'sh8000,   16'sh8001,   16'sh8000));
    directed.push_back(make_op(KIND_ADD,     16'sh8000,   16'sh8001,   16'sh8001,   16'sh8000));
    directed.push_back(make_op(KIND_RED,     16'sh8000,  -16'sd1,      16'sd0,      16'sd0));
    directed.push_back(make_op(KIND_RED,     16'sh7fff,   16'sh8000,   16'sh7fff,   16'sh7fff));
    directed.push_back(make_op(KIND_RED_ALT, -16'sd1,     16'sh8000,   16'sh8000,   16'sh8000));
    directed.push_back(make_op(KIND_ADD,    -16'sd1,     -16'sd1,     -16'sd1,     -16'sd1));
    directed.push_back(make_op(KIND_MUL,     16'sd1,     -16'sd1,     -16'sd1,      16'sd1));
    directed.push_back(make_op(KIND_ADD,     16'sd12345, -16'sd4321,  -16'sd999,    16'sd777));
    // consecutive Fibonacci numbers: the longest Euclid run at this width
    directed.push_back(make_op(KIND_RED,     16'sd28657,  16'sd17711,  16'sd1,      16'sd1));
    foreach (directed[i])
      send_item(directed[i]);

    // random part: bursts of items separated by random gaps, some back to back
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_item(random_op());
        sent++;
        if (sent == HOLD_AT_ITEM)
          long_hold_armed <= 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        op_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    op_valid <= 1'b0;

    // every item gives a result; then watch a little longer for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fault_count == 0)
      $display("rational_add_multiply_reduce_core verification clean");
    else
      $display("rational_add_multiply_reduce_core verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/rarm_pkg.sv
hdl/rarm_div.sv
hdl/rational_add_multiply_reduce_core.sv
verif/tb_rational_add_multiply_reduce_core.sv
